FILE: src/tool_flange_can_status_decoder_defines.svh
// assertion macros for the tool flange can status decoder
`ifndef TOOL_FLANGE_CAN_STATUS_DECODER_DEFINES_SVH
`define TOOL_FLANGE_CAN_STATUS_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define TFCSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tfcsd assertion failed");
`define TFCSD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tfcsd assertion failed");
`else
`define TFCSD_ASSERT(lbl, prop)
`define TFCSD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: src/tfcsd_pkg.sv
// types and constants of the tool flange can status decoder
`timescale 1ns / 1ps

package tfcsd_pkg;

  typedef logic [1:0]         req_t;
  typedef logic [3:0]         chan_t;
  typedef logic [10:0]        can_id_t;
  typedef logic [3:0]         dlc_t;
  typedef logic [63:0]        payload_t;
  typedef logic [7:0]         count_t;
  typedef logic signed [15:0] raw_word_t;
  typedef logic [6:0]         temp_t;
  typedef logic [9:0]         io_t;
  typedef logic [5:0]         volts_t;
  typedef logic [31:0]        version_t;
  typedef logic [48:0]        general_t;
  typedef logic [3:0]         cfg_index_t;
  typedef logic [7:0]         cfg_data_t;

  localparam req_t REQ_FRAME = 2'd0;
  localparam req_t REQ_TICK  = 2'd1;
  localparam req_t REQ_CLEAR = 2'd2;

  localparam can_id_t ID_GYRO    = 11'h110;
  localparam can_id_t ID_ACCEL   = 11'h111;
  localparam can_id_t ID_GENERAL = 11'h120;

  localparam cfg_index_t CFG_OWN_CHANNEL   = 4'd0;
  localparam cfg_index_t CFG_TIMEOUT_LIMIT = 4'd1;

  localparam count_t TIMEOUT_RESET = 8'd200;
  localparam dlc_t   SUBTYPE_MIN_LEN = 4'd6;
  localparam logic [7:0] TYPE_VERSION = 8'd1;

endpackage

FILE: src/tfcsd_intf.sv
// handshake channel interfaces of the tool flange can status decoder
`timescale 1ns / 1ps

interface tfcsd_in_if;
  import tfcsd_pkg::*;
  logic     valid;
  logic     ready;
  req_t     req_type;
  chan_t    channel;
  can_id_t  frame_id;
  dlc_t     frame_length;
  payload_t payload;
  count_t   tick_amount;
  modport source (output valid, req_type, channel, frame_id, frame_length, payload,
                  tick_amount, input ready);
  modport sink (input valid, req_type, channel, frame_id, frame_length, payload,
                tick_amount, output ready);
endinterface

interface tfcsd_out_if;
  import tfcsd_pkg::*;
  logic      valid;
  logic      ready;
  raw_word_t gyro_x;
  raw_word_t gyro_y;
  raw_word_t gyro_z;
  raw_word_t accel_x;
  raw_word_t accel_y;
  raw_word_t accel_z;
  temp_t     temperature;
  io_t       io_bits;
  volts_t    supply_volts;
  logic      link_up;
  version_t  ctrl_version;
  general_t  general_record;
  modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                  temperature, io_bits, supply_volts, link_up, ctrl_version,
                  general_record, input ready);
  modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                temperature, io_bits, supply_volts, link_up, ctrl_version,
                general_record, output ready);
endinterface

interface tfcsd_cfg_if;
  import tfcsd_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/tool_flange_can_status_decoder.sv
// top level of the tool flange can status decoder
`timescale 1ns / 1ps
`include "tool_flange_can_status_decoder_defines.svh"

// tool flange can status decoder
// in_ch carries one word per item: a received can frame, a watchdog tick
// or a request to clear the general record. frames on a channel other than
// own_channel change nothing. out_ch returns one status snapshot per item.
// cfg_ch writes own_channel (index 0) and timeout_limit (index 1); it is
// always ready and must only be used while the block is idle.
// the snapshot of an item is valid on out_ch in the cycle after the item is
// accepted. throughput: one item per cycle unless the receiver stalls, set
// by the single snapshot register, which also holds the decoded state.
// in_ch.ready is high while the snapshot register is empty or being taken
// in the same cycle; when the receiver stalls, the snapshot holds and
// in_ch.ready stays low.
// reset clears all decoded state, sets the watchdog count and timeout
// limit to 200, own_channel to 0, and empties the output.

module tool_flange_can_status_decoder (
  input  logic        clk,
  input  logic        rst_n,
  tfcsd_in_if.sink    in_ch,
  tfcsd_out_if.source out_ch,
  tfcsd_cfg_if.sink   cfg_ch
);
  import tfcsd_pkg::*;

  chan_t     own_channel_r;
  count_t    timeout_limit_r;
  raw_word_t gyro_r [3];
  raw_word_t accel_r [3];
  temp_t     temp_r;
  io_t       io_r;
  volts_t    volts_r;
  count_t    wd_r;
  logic      link_r;
  version_t  version_r;
  general_t  general_r;
  logic      out_valid_r;

  logic       in_accept;
  logic       frame_hit;
  logic [7:0] b6;
  logic [7:0] b7;
  logic [8:0] wd_sum;
  logic       wd_sat;
  logic [7:0] sub_byte;
  volts_t     volts_nxt;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign frame_hit = (in_ch.req_type == REQ_FRAME) && (in_ch.channel == own_channel_r);
  assign b6        = in_ch.payload[55:48];
  assign b7        = in_ch.payload[63:56];
  assign wd_sum    = {1'b0, wd_r} + {1'b0, in_ch.tick_amount};
  assign wd_sat    = wd_sum >= {1'b0, timeout_limit_r};
  assign sub_byte  = (in_ch.frame_length >= SUBTYPE_MIN_LEN) ? in_ch.payload[47:40] : 8'd0;
  // code times 12 as code times 8 plus code times 4
  assign volts_nxt = {1'b0, b7[1:0], 3'b000} + {2'b00, b7[1:0], 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_channel_r   <= '0;
      timeout_limit_r <= TIMEOUT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_OWN_CHANNEL:   own_channel_r   <= cfg_ch.data[3:0];
        CFG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        gyro_r[i]  <= '0;
        accel_r[i] <= '0;
      end
      temp_r    <= '0;
      io_r      <= '0;
      volts_r   <= '0;
      wd_r      <= TIMEOUT_RESET;
      link_r    <= 1'b0;
      version_r <= '0;
      general_r <= '0;
    end else if (in_accept) begin
      if (frame_hit && (in_ch.frame_id == ID_GYRO)) begin
        for (int i = 0; i < 3; i++) begin
          gyro_r[i] <= in_ch.payload[16*i +: 16];
        end
        io_r[5:2] <= {b6[4], b6[5], b6[6], b6[7]};
      end
      if (frame_hit && (in_ch.frame_id == ID_ACCEL)) begin
        for (int i = 0; i < 3; i++) begin
          accel_r[i] <= in_ch.payload[16*i +: 16];
        end
        temp_r  <= b6[6:0];
        io_r[1:0] <= {b7[6], b7[7]};
        io_r[9:6] <= {b7[3], b6[7], b7[4], b7[5]};
        volts_r <= volts_nxt;
        wd_r    <= '0;
        link_r  <= 1'b1;
      end
      if (frame_hit && (in_ch.frame_id == ID_GENERAL)) begin
        general_r <= {1'b1, sub_byte, in_ch.payload[7:0], in_ch.payload[39:8]};
        if (in_ch.payload[7:0] == TYPE_VERSION) begin
          version_r <= in_ch.payload[39:8];
        end
      end
      if (in_ch.req_type == REQ_TICK) begin
        if (wd_sat) begin
          wd_r   <= timeout_limit_r;
          link_r <= 1'b0;
        end else begin
          wd_r <= wd_sum[7:0];
        end
      end
      if (in_ch.req_type == REQ_CLEAR) begin
        general_r <= '0;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.gyro_x           = gyro_r[0];
  assign out_ch.gyro_y           = gyro_r[1];
  assign out_ch.gyro_z           = gyro_r[2];
  assign out_ch.accel_x          = accel_r[0];
  assign out_ch.accel_y          = accel_r[1];
  assign out_ch.accel_z          = accel_r[2];
  assign out_ch.temperature      = temp_r;
  assign out_ch.io_bits          = io_r;
  assign out_ch.supply_volts     = volts_r;
  assign out_ch.link_up          = link_r;
  assign out_ch.ctrl_version     = version_r;
  assign out_ch.general_record   = general_r;

  // watchdog never passes the limit after a tick
  `TFCSD_ASSERT(a_wd_bound, in_accept && (in_ch.req_type == REQ_TICK) |=> wd_r <= timeout_limit_r)
  // saturating tick drops the link
  `TFCSD_ASSERT(a_wd_drop, in_accept && (in_ch.req_type == REQ_TICK) && wd_sat |=> !link_r)
  // accepted accel frame raises the link in its snapshot
  `TFCSD_ASSERT(a_link_set, in_accept && frame_hit && (in_ch.frame_id == ID_ACCEL) |=> out_ch.valid && link_r && (wd_r == 8'd0))
  // clear request empties the general record
  `TFCSD_ASSERT(a_clear, in_accept && (in_ch.req_type == REQ_CLEAR) |=> general_r == '0)
  // a new snapshot only follows an accepted word
  `TFCSD_ASSERT(a_valid_src, $rose(out_valid_r) |-> $past(in_accept))

endmodule

FILE: tb/tb_tool_flange_can_status_decoder.sv
// self-checking testbench of the tool flange can status decoder, random traffic with a status predictor
`timescale 1ns / 1ps

module tb_tool_flange_can_status_decoder;
  import tfcsd_pkg::*;

  localparam req_t REQ_UNUSED      = 2'd3;
  localparam int   VOLTS_PER_CODE  = 12;
  localparam int   STALL_LIMIT     = 5000;
  localparam int   ITEMS_PER_PHASE = 300;
  localparam int   NUM_PHASES      = 5;

  typedef struct packed {
    req_t     req;
    chan_t    channel;
    can_id_t  id;
    dlc_t     len;
    payload_t payload;
    count_t   tick;
  } can_req_t;

  typedef struct packed {
    raw_word_t gyro_x;
    raw_word_t gyro_y;
    raw_word_t gyro_z;
    raw_word_t accel_x;
    raw_word_t accel_y;
    raw_word_t accel_z;
    temp_t     temperature;
    io_t       io_bits;
    volts_t    supply_volts;
    logic      link_up;
    version_t  ctrl_version;
    general_t  general_record;
  } status_t;

  logic clk;
  logic rst_n;

  tfcsd_in_if  in_ch();
  tfcsd_out_if out_ch();
  tfcsd_cfg_if cfg_ch();

  tool_flange_can_status_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // decoder state as predicted
  raw_word_t gyro_q[3];
  raw_word_t accel_q[3];
  temp_t     temp_q;
  io_t       io_q;
  volts_t    volts_q;
  count_t    wd_q;
  logic      link_q;
  version_t  version_q;
  general_t  general_q;
  chan_t     own_ch_q;
  count_t    limit_q;

  can_req_t pending_reqs[$];
  status_t  expected_status[$];
  can_req_t cur_req;
  status_t  predicted;
  status_t  want;
  int       mismatches;
  int       gap_left;
  int       stall_left;
  int       calm_in;
  int       calm_out;
  int       idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic decode_item(input can_req_t r, output status_t s);
    logic [8:0] sum;
    logic [7:0] b6;
    logic [7:0] b7;
    logic [7:0] sub;
    int         i;
    b6 = r.payload[55:48];
    b7 = r.payload[63:56];
    case (r.req)
      REQ_FRAME: begin
        if (r.channel == own_ch_q) begin
          if (r.id == ID_GYRO) begin
            for (i = 0; i < 3; i++) gyro_q[i] = r.payload[16*i +: 16];
            io_q[5:2] = {b6[4], b6[5], b6[6], b6[7]};
          end else if (r.id == ID_ACCEL) begin
            wd_q = '0;
            link_q = 1'b1;
            for (i = 0; i < 3; i++) accel_q[i] = r.payload[16*i +: 16];
            temp_q = b6[6:0];
            io_q[1:0] = {b7[6], b7[7]};
            io_q[7:6] = {b7[4], b7[5]};
            io_q[8] = b6[7];
            io_q[9] = b7[3];
            volts_q = volts_t'(b7[1:0] * VOLTS_PER_CODE);
          end else if (r.id == ID_GENERAL) begin
            sub = (r.len >= SUBTYPE_MIN_LEN) ? r.payload[47:40] : 8'd0;
            general_q = {1'b1, sub, r.payload[7:0], r.payload[39:8]};
            if (r.payload[7:0] == TYPE_VERSION) version_q = r.payload[39:8];
          end
        end
      end
      REQ_TICK: begin
        sum = {1'b0, wd_q} + {1'b0, r.tick};
        if (sum >= {1'b0, limit_q}) begin
          wd_q = limit_q;
          link_q = 1'b0;
        end else begin
          wd_q = sum[7:0];
        end
      end
      REQ_CLEAR: begin
        general_q = '0;
      end
      default: begin
      end
    endcase
    s.gyro_x = gyro_q[0];
    s.gyro_y = gyro_q[1];
    s.gyro_z = gyro_q[2];
    s.accel_x = accel_q[0];
    s.accel_y = accel_q[1];
    s.accel_z = accel_q[2];
    s.temperature = temp_q;
    s.io_bits = io_q;
    s.supply_volts = volts_q;
    s.link_up = link_q;
    s.ctrl_version = version_q;
    s.general_record = general_q;
  endtask

  function automatic void enqueue(req_t req, chan_t ch, can_id_t id, dlc_t len, payload_t p,
                                  count_t tick);
    can_req_t r;
    r.req = req;
    r.channel = ch;
    r.id = id;
    r.len = len;
    r.payload = p;
    r.tick = tick;
    pending_reqs.push_back(r);
  endfunction

  // mostly well-formed frames for this channel, with ticks, clears and noise
  function automatic can_req_t random_req();
    can_req_t r;
    int       pick;
    r.req = REQ_FRAME;
    r.channel = own_ch_q;
    r.id = can_id_t'($urandom_range(0, 2047));
    r.len = dlc_t'($urandom_range(0, 15));
    r.payload = {$urandom, $urandom};
    r.tick = count_t'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      r.id = ID_GYRO;
    end else if (pick < 50) begin
      r.id = ID_ACCEL;
    end else if (pick < 65) begin
      r.id = ID_GENERAL;
      if ($urandom_range(0, 1)) r.payload[7:0] = TYPE_VERSION;
      if ($urandom_range(0, 1)) r.len = 4'd8;
    end else if (pick < 77) begin
      r.req = REQ_TICK;
      r.channel = chan_t'($urandom_range(0, 15));
      if ($urandom_range(0, 3) != 0) r.tick = count_t'($urandom_range(0, 15));
    end else if (pick < 82) begin
      r.req = REQ_CLEAR;
      r.channel = chan_t'($urandom_range(0, 15));
    end else if (pick < 86) begin
      r.req = REQ_UNUSED;
      r.channel = chan_t'($urandom_range(0, 15));
    end else if (pick < 93) begin
      r.channel = chan_t'($urandom_range(0, 15));
    end
    return r;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) == 0) calm = $urandom_range(50, 150);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  task automatic write_reg(cfg_index_t idx, cfg_data_t val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_OWN_CHANNEL) own_ch_q = val[3:0];
    else if (idx == CFG_TIMEOUT_LIMIT) limit_q = val;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_status.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // input word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_item(cur_req, predicted);
        expected_status.push_back(predicted);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_ch.req_type <= cur_req.req;
          in_ch.channel <= cur_req.channel;
          in_ch.frame_id <= cur_req.id;
          in_ch.frame_length <= cur_req.len;
          in_ch.payload <= cur_req.payload;
          in_ch.tick_amount <= cur_req.tick;
          in_ch.valid <= 1'b1;
          gap_left = pick_gap(calm_in);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // status receiver with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap(calm_out);
    end
  end

  // status word monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_status.size() == 0) begin
        $error("status word with nothing expected");
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("gyro_x", want.gyro_x, out_ch.gyro_x);
        check_field("gyro_y", want.gyro_y, out_ch.gyro_y);
        check_field("gyro_z", want.gyro_z, out_ch.gyro_z);
        check_field("accel_x", want.accel_x, out_ch.accel_x);
        check_field("accel_y", want.accel_y, out_ch.accel_y);
        check_field("accel_z", want.accel_z, out_ch.accel_z);
        check_field("temperature", want.temperature, out_ch.temperature);
        check_field("io_bits", want.io_bits, out_ch.io_bits);
        check_field("supply_volts", want.supply_volts, out_ch.supply_volts);
        check_field("link_up", want.link_up, out_ch.link_up);
        check_field("ctrl_version", want.ctrl_version, out_ch.ctrl_version);
        check_field("general_record", want.general_record, out_ch.general_record);
      end
    end
  end

  // hang detection
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tool_flange_can_status_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    int phase;
    int n;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_FRAME;
    in_ch.channel = '0;
    in_ch.frame_id = '0;
    in_ch.frame_length = '0;
    in_ch.payload = '0;
    in_ch.tick_amount = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_OWN_CHANNEL;
    cfg_ch.data = '0;
    for (n = 0; n < 3; n++) begin
      gyro_q[n] = '0;
      accel_q[n] = '0;
    end
    temp_q = '0;
    io_q = '0;
    volts_q = '0;
    wd_q = TIMEOUT_RESET;
    link_q = 1'b0;
    version_q = '0;
    general_q = '0;
    own_ch_q = '0;
    limit_q = TIMEOUT_RESET;
    mismatches = 0;
    gap_left = 0;
    stall_left = 0;
    calm_in = 0;
    calm_out = 0;
    idle_cycles = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings
    enqueue(REQ_UNUSED, 4'hF, 11'h7FF, 4'hF, '1, 8'hFF);
    enqueue(REQ_TICK, 4'h0, 11'h000, 4'h0, '0, 8'd0);
    enqueue(REQ_FRAME, 4'h0, ID_GYRO, 4'd8, '1, 8'd0);
    enqueue(REQ_FRAME, 4'h0, ID_ACCEL, 4'd8, '1, 8'd0);
    enqueue(REQ_FRAME, 4'h0, ID_GYRO, 4'd8, 64'h00A0_8000_7FFF_0000, 8'd0);
    enqueue(REQ_FRAME, 4'h0, ID_ACCEL, 4'd8, 64'h5AC3_8000_7FFF_0001, 8'd0);
    enqueue(REQ_FRAME, 4'h0, ID_ACCEL, 4'd0, '0, 8'd0);
    enqueue(REQ_FRAME, 4'h0, ID_GENERAL, 4'd8, 64'hFFFF_FFFF_FFFF_FF01, 8'd0);
    enqueue(REQ_FRAME, 4'h0, ID_GENERAL, 4'd5, 64'h0000_AB12_3456_7801, 8'd0);
    enqueue(REQ_FRAME, 4'h0, ID_GENERAL, 4'd6, 64'h0000_CD87_6543_2102, 8'd0);
    enqueue(REQ_FRAME, 4'h0, ID_GENERAL, 4'd15, 64'hFFFF_EE00_0000_00FF, 8'd0);
    enqueue(REQ_FRAME, 4'h0, ID_GENERAL, 4'd0, '0, 8'd0);
    enqueue(REQ_CLEAR, 4'h0, 11'h000, 4'h0, '0, 8'd0);
    enqueue(REQ_FRAME, 4'hF, ID_GYRO, 4'd8, '1, 8'd0);
    enqueue(REQ_FRAME, 4'h0, 11'h7FF, 4'd8, '1, 8'd0);
    enqueue(REQ_FRAME, 4'h0, 11'h000, 4'd8, '1, 8'd0);
    enqueue(REQ_FRAME, 4'h0, ID_ACCEL, 4'd8, {$urandom, $urandom}, 8'd0);
    enqueue(REQ_TICK, 4'hF, 11'h7FF, 4'hF, '1, 8'd199);
    enqueue(REQ_TICK, 4'h0, 11'h000, 4'h0, '0, 8'd1);
    enqueue(REQ_FRAME, 4'h0, ID_ACCEL, 4'd8, {$urandom, $urandom}, 8'd0);
    enqueue(REQ_TICK, 4'h0, 11'h000, 4'h0, '0, 8'd255);
    enqueue(REQ_TICK, 4'h0, 11'h000, 4'h0, '0, 8'd255);
    wait_idle();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_OWN_CHANNEL, 8'd15);
          write_reg(CFG_TIMEOUT_LIMIT, 8'd255);
        end
        1: begin
          write_reg(CFG_TIMEOUT_LIMIT, 8'd1);
          write_reg(CFG_OWN_CHANNEL, 8'd0);
        end
        2: begin
          write_reg(CFG_OWN_CHANNEL, cfg_data_t'($urandom_range(0, 15)));
          write_reg(CFG_TIMEOUT_LIMIT, 8'd0);
        end
        3: begin
          write_reg(CFG_OWN_CHANNEL, cfg_data_t'($urandom_range(0, 15)));
          write_reg(CFG_TIMEOUT_LIMIT, cfg_data_t'($urandom_range(2, 254)));
        end
        default: begin
          write_reg(CFG_OWN_CHANNEL, cfg_data_t'($urandom_range(0, 15)));
          write_reg(CFG_TIMEOUT_LIMIT, TIMEOUT_RESET);
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) pending_reqs.push_back(random_req());
      wait_idle();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("tool_flange_can_status_decoder regression: pass");
    end else begin
      $display("tool_flange_can_status_decoder regression: fail");
    end
    $finish;
  end

endmodule
